[sv/refcounted_handle_allocator_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the handle allocator core
// Same-cycle and next-cycle implication checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_HANDLE_ALLOCATOR_CORE_MACROS_SVH
`define REFCOUNTED_HANDLE_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RHAC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhac: same-cycle check failed");
`define RHAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhac: next-cycle check failed");
`else
`define RHAC_ASSERT_NOW(label, ante, cons)
`define RHAC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[sv/rhac_pkg.sv]
// ----------------------------------------------------------------------------
// rhac_pkg
// Types and constants shared by the handle allocator core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhac_pkg;

    localparam int ENTRIES    = 128;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int DEPTH_W    = $clog2(ENTRIES + 1);

    localparam int HANDLE_W   = 8;
    localparam int CNT_OUT_W  = 16;
    localparam int STATUS_W   = 3;
    localparam int FREE_W     = 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [HANDLE_W:0]     HANDLE_TOP = (HANDLE_W + 1)'(ENTRIES);
    localparam logic [DEPTH_W-1:0]    DEPTH_FULL = DEPTH_W'(ENTRIES);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_REL   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STACK,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]          operation;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]  granted_handle;
        logic                 entry_freed;
        logic [CNT_OUT_W-1:0] ref_count_after;
        logic [STATUS_W-1:0]  status;
        logic [FREE_W-1:0]    free_entries;
    } rsp_t;

    typedef struct packed {
        logic [1:0]            op;
        logic                  bad;
        logic [IDX_W-1:0]      idx;
        logic [COUNT_BITS-1:0] count;
        logic [DEPTH_W-1:0]    depth;
    } exec_in_t;

    typedef struct packed {
        logic                  cnt_we;
        logic [COUNT_BITS-1:0] cnt_wdata;
        logic                  stk_we;
        logic [IDX_W-1:0]      stk_waddr;
        logic [IDX_W-1:0]      stk_wdata;
        logic [DEPTH_W-1:0]    depth;
    } exec_upd_t;

endpackage

[sv/rhac_ram.sv]
// ----------------------------------------------------------------------------
// rhac_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhac_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/rhac_exec.sv]
// ----------------------------------------------------------------------------
// rhac_exec
// Count update, stack push/pop and response build for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhac_exec import rhac_pkg::*; (
    input  exec_in_t  x,
    output exec_upd_t upd,
    output rsp_t      rsp
);

    always_comb
    begin
        upd = '0;
        rsp = '0;
        upd.depth = x.depth;
        unique case (x.op)
            OP_ALLOC:
            begin
                if (x.bad)
                begin
                    rsp.status = ST_FULL;
                end
                else
                begin
                    upd.depth              = x.depth - DEPTH_W'(1);
                    rsp.granted_handle     = HANDLE_W'(x.idx) + HANDLE_W'(1);
                    rsp.ref_count_after    = CNT_OUT_W'(x.count);
                end
            end
            OP_ADD:
            begin
                if (x.bad)
                begin
                    rsp.status = ST_BAD;
                end
                else if (x.count == COUNT_MAX)
                begin
                    rsp.status          = ST_SAT;
                    rsp.ref_count_after = CNT_OUT_W'(COUNT_MAX);
                end
                else
                begin
                    upd.cnt_we          = 1'b1;
                    upd.cnt_wdata       = x.count + COUNT_BITS'(1);
                    rsp.ref_count_after = CNT_OUT_W'(upd.cnt_wdata);
                end
            end
            OP_REL:
            begin
                if (x.bad)
                begin
                    rsp.status = ST_BAD;
                end
                else if (x.count == '0)
                begin
                    rsp.status = ST_UNDER;
                end
                else
                begin
                    upd.cnt_we          = 1'b1;
                    upd.cnt_wdata       = x.count - COUNT_BITS'(1);
                    rsp.ref_count_after = CNT_OUT_W'(upd.cnt_wdata);
                    if (upd.cnt_wdata == '0)
                    begin
                        rsp.entry_freed = 1'b1;
                        if (x.depth < DEPTH_FULL)
                        begin
                            upd.stk_we    = 1'b1;
                            upd.stk_waddr = x.depth[IDX_W-1:0];
                            upd.stk_wdata = x.idx;
                            upd.depth     = x.depth + DEPTH_W'(1);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        rsp.free_entries = FREE_W'(upd.depth);
    end

endmodule

[sv/refcounted_handle_allocator_core.sv]
// ----------------------------------------------------------------------------
// refcounted_handle_allocator_core
// Handle allocator with a free-index stack and per-entry reference counts.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals                   | Payload
// req     | in        | req_valid / req_ready     | req_t: operation, handle
// rsp     | out       | rsp_valid / rsp_ready     | rsp_t: granted_handle .. free_entries
//
// Add and release: count RAM read, then update and write back.
// Allocate: stack RAM read, then count RAM read, then finish.
// A full table, a bad handle or an unknown operation goes straight to the finish step.
// Reset clears the valid bits of both RAMs; no clearing pass is needed.
// A response waiting on rsp_ready holds the block in its final step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "refcounted_handle_allocator_core_macros.svh"

module refcounted_handle_allocator_core import rhac_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    state_t                state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic                  bad_reg, bad_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      saddr_reg, saddr_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;
    logic [ENTRIES-1:0]    stk_vld_reg, stk_vld_next;
    logic [ENTRIES-1:0]    cnt_vld_reg, cnt_vld_next;

    logic                  stk_rd_en, cnt_rd_en;
    logic [IDX_W-1:0]      stk_rd_addr, cnt_rd_addr;
    logic [IDX_W-1:0]      stk_rd_data;
    logic [COUNT_BITS-1:0] cnt_rd_data;
    logic                  finish;
    logic                  h_bad;
    exec_in_t              ex_in;
    exec_upd_t             ex_upd;
    rsp_t                  ex_rsp;

    rhac_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_stack_ram (
        .clk     (clk),
        .wr_en   (finish && ex_upd.stk_we),
        .wr_addr (ex_upd.stk_waddr),
        .wr_data (ex_upd.stk_wdata),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    rhac_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES)) u_count_ram (
        .clk     (clk),
        .wr_en   (finish && ex_upd.cnt_we),
        .wr_addr (idx_reg),
        .wr_data (ex_upd.cnt_wdata),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    always_comb
    begin
        ex_in.op    = op_reg;
        ex_in.bad   = bad_reg;
        ex_in.idx   = idx_reg;
        ex_in.count = cnt_vld_reg[idx_reg] ? cnt_rd_data : '0;
        ex_in.depth = depth_reg;
    end

    rhac_exec u_exec (
        .x   (ex_in),
        .upd (ex_upd),
        .rsp (ex_rsp)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign h_bad     = (req.handle == '0) || ({1'b0, req.handle} > HANDLE_TOP);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        bad_next       = bad_reg;
        idx_next       = idx_reg;
        saddr_next     = saddr_reg;
        depth_next     = depth_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        stk_vld_next   = stk_vld_reg;
        cnt_vld_next   = cnt_vld_reg;
        stk_rd_en      = 1'b0;
        stk_rd_addr    = saddr_reg;
        cnt_rd_en      = 1'b0;
        cnt_rd_addr    = idx_reg;
        finish         = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    state_next = S_EXEC;
                    bad_next   = 1'b0;
                    priority if (req.operation == OP_ALLOC)
                    begin
                        if (depth_reg == '0)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            stk_rd_en   = 1'b1;
                            stk_rd_addr = IDX_W'(depth_reg - DEPTH_W'(1));
                            saddr_next  = stk_rd_addr;
                            state_next  = S_STACK;
                        end
                    end
                    else if (req.operation == OP_ADD || req.operation == OP_REL)
                    begin
                        bad_next    = h_bad;
                        idx_next    = IDX_W'(req.handle - HANDLE_W'(1));
                        cnt_rd_en   = !h_bad;
                        cnt_rd_addr = idx_next;
                    end
                    else
                    begin
                        bad_next = 1'b0;
                    end
                end
            end
            S_STACK:
            begin
                idx_next    = stk_vld_reg[saddr_reg] ? stk_rd_data : saddr_reg;
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = idx_next;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    finish         = 1'b1;
                    rsp_next       = ex_rsp;
                    rsp_valid_next = 1'b1;
                    depth_next     = ex_upd.depth;
                    state_next     = S_IDLE;
                    if (ex_upd.stk_we)
                    begin
                        stk_vld_next[ex_upd.stk_waddr] = 1'b1;
                    end
                    if (ex_upd.cnt_we)
                    begin
                        cnt_vld_next[idx_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= DEPTH_FULL;
            rsp_valid_reg <= 1'b0;
            stk_vld_reg   <= '0;
            cnt_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            rsp_valid_reg <= rsp_valid_next;
            stk_vld_reg   <= stk_vld_next;
            cnt_vld_reg   <= cnt_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        bad_reg   <= bad_next;
        idx_reg   <= idx_next;
        saddr_reg <= saddr_next;
        rsp_reg   <= rsp_next;
    end

    `RHAC_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_reg != S_IDLE)
    `RHAC_ASSERT_NOW(a_full_empty, rsp_valid_reg && rsp_reg.status == ST_FULL, rsp_reg.free_entries == '0)
    `RHAC_ASSERT_NOW(a_freed_zero, rsp_valid_reg && rsp_reg.entry_freed, rsp_reg.ref_count_after == '0 && rsp_reg.status == ST_OK)
    `RHAC_ASSERT_NOW(a_grant_ok, rsp_valid_reg && rsp_reg.granted_handle != '0, rsp_reg.status == ST_OK)

endmodule

[test/tb_refcounted_handle_allocator_core.sv]
// ----------------------------------------------------------------------------
// tb_refcounted_handle_allocator_core
// Self-checking bench for the handle allocator: directed requests, a table
// fill to exhaustion, then random request traffic with valid/ready idling
// on both channels in stretches. Each response is compared with its written
// expectation or a cycle-free model of the free stack and reference counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_refcounted_handle_allocator_core;
    import rhac_pkg::*;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         RANDOM_REQS  = 1700;

    typedef struct packed {
        req_t r;
        logic lit;
        rsp_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // model state
    logic [IDX_W-1:0]      free_idx [ENTRIES];
    logic [DEPTH_W-1:0]    free_top;
    logic [COUNT_BITS-1:0] ref_cnt [ENTRIES];
    bit                    in_use [ENTRIES];

    rsp_t expected_rsp [$];
    rsp_t want_rsp;
    bit   idling_on;
    int   stall_left;
    int   mismatch_count;
    int   reqs_sent;
    int   rsps_checked;

    refcounted_handle_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("refcounted_handle_allocator_core regression: fail");
        $finish;
    end

    function automatic rsp_t predict_response(input req_t r);
        rsp_t                  o;
        logic [IDX_W-1:0]      idx;
        logic [COUNT_BITS-1:0] c;
        o = '0;
        case (r.operation)
            OP_ALLOC:
            begin
                if (free_top == 0)
                    o.status = ST_FULL;
                else
                begin
                    free_top = free_top - 1'b1;
                    idx = free_idx[free_top[IDX_W-1:0]];
                    o.granted_handle = HANDLE_W'(idx) + 1'b1;
                    o.ref_count_after = CNT_OUT_W'(ref_cnt[idx]);
                    in_use[idx] = 1'b1;
                end
            end
            OP_ADD, OP_REL:
            begin
                if (r.handle == 0 || r.handle > ENTRIES)
                    o.status = ST_BAD;
                else
                begin
                    idx = IDX_W'(r.handle - 1'b1);
                    c = ref_cnt[idx];
                    if (r.operation == OP_ADD)
                    begin
                        if (c == COUNT_MAX)
                            o.status = ST_SAT;
                        else
                            c = c + 1'b1;
                    end
                    else if (c == 0)
                        o.status = ST_UNDER;
                    else
                    begin
                        c = c - 1'b1;
                        if (c == 0)
                        begin
                            o.entry_freed = 1'b1;
                            in_use[idx] = 1'b0;
                            if (free_top < DEPTH_FULL)
                            begin
                                free_idx[free_top[IDX_W-1:0]] = idx;
                                free_top = free_top + 1'b1;
                            end
                        end
                    end
                    ref_cnt[idx] = c;
                    o.ref_count_after = CNT_OUT_W'(c);
                end
            end
            default: ;
        endcase
        o.free_entries = FREE_W'(free_top);
        return o;
    endfunction

    // random live entry: one holding references, or one currently granted
    function automatic int pick_entry(input bit with_refs);
        int start;
        int i;
        int j;
        start = $urandom_range(0, ENTRIES - 1);
        for (i = 0; i < ENTRIES; i++)
        begin
            j = (start + i) % ENTRIES;
            if (with_refs ? (ref_cnt[j] != 0) : in_use[j])
                return j;
        end
        return -1;
    endfunction

    function automatic row_t plan_row(input logic [1:0] op, input logic [7:0] h,
                                      input logic lit, input logic [7:0] gh,
                                      input logic fr, input logic [15:0] cnt,
                                      input logic [2:0] st, input logic [7:0] fe);
        row_t row;
        row.r.operation           = op;
        row.r.handle              = h;
        row.lit                   = lit;
        row.want.granted_handle   = gh;
        row.want.entry_freed      = fr;
        row.want.ref_count_after  = cnt;
        row.want.status           = st;
        row.want.free_entries     = fe;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic send_request(input req_t r, input logic lit, input rsp_t lit_rsp);
        rsp_t pred;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        else
            @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        pred = predict_response(r);
        expected_rsp.push_back(lit ? lit_rsp : pred);
        reqs_sent++;
    endtask

    task automatic drain;
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // response side: random ready stalls
    initial
    begin
        rsp_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("response with no request pending", rsp.granted_handle, 0);
            else
            begin
                want_rsp = expected_rsp.pop_front();
                rsps_checked++;
                if (rsp.granted_handle !== want_rsp.granted_handle)
                    report_mismatch("granted_handle", rsp.granted_handle,
                                    want_rsp.granted_handle);
                if (rsp.entry_freed !== want_rsp.entry_freed)
                    report_mismatch("entry_freed", rsp.entry_freed, want_rsp.entry_freed);
                if (rsp.ref_count_after !== want_rsp.ref_count_after)
                    report_mismatch("ref_count_after", rsp.ref_count_after,
                                    want_rsp.ref_count_after);
                if (rsp.status !== want_rsp.status)
                    report_mismatch("status", rsp.status, want_rsp.status);
                if (rsp.free_entries !== want_rsp.free_entries)
                    report_mismatch("free_entries", rsp.free_entries, want_rsp.free_entries);
            end
        end
    end

    initial
    begin
        int   n;
        int   k;
        int   sel;
        req_t stim;
        row_t plan [$];

        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        idling_on      = 1'b1;
        mismatch_count = 0;
        reqs_sent      = 0;
        rsps_checked   = 0;
        for (n = 0; n < ENTRIES; n++)
        begin
            free_idx[n] = IDX_W'(n);
            ref_cnt[n]  = '0;
            in_use[n]   = 1'b0;
        end
        free_top = DEPTH_FULL;

        //                     op        handle  lit   grant  fr    cnt    status    free
        plan.push_back(plan_row(OP_ALLOC, 8'd0,   1'b1, 8'd128, 1'b0, 16'd0, ST_OK,    8'd127));
        plan.push_back(plan_row(OP_ADD,   8'd128, 1'b1, 8'd0,   1'b0, 16'd1, ST_OK,    8'd127));
        plan.push_back(plan_row(OP_ADD,   8'd128, 1'b1, 8'd0,   1'b0, 16'd2, ST_OK,    8'd127));
        plan.push_back(plan_row(OP_REL,   8'd128, 1'b1, 8'd0,   1'b0, 16'd1, ST_OK,    8'd127));
        plan.push_back(plan_row(OP_REL,   8'd128, 1'b1, 8'd0,   1'b1, 16'd0, ST_OK,    8'd128));
        plan.push_back(plan_row(OP_REL,   8'd128, 1'b1, 8'd0,   1'b0, 16'd0, ST_UNDER, 8'd128));
        plan.push_back(plan_row(OP_ADD,   8'd0,   1'b1, 8'd0,   1'b0, 16'd0, ST_BAD,   8'd128));
        plan.push_back(plan_row(OP_REL,   8'd0,   1'b1, 8'd0,   1'b0, 16'd0, ST_BAD,   8'd128));
        plan.push_back(plan_row(OP_ADD,   8'd129, 1'b1, 8'd0,   1'b0, 16'd0, ST_BAD,   8'd128));
        plan.push_back(plan_row(OP_REL,   8'd255, 1'b1, 8'd0,   1'b0, 16'd0, ST_BAD,   8'd128));
        plan.push_back(plan_row(OP_NONE,  8'd255, 1'b1, 8'd0,   1'b0, 16'd0, ST_OK,    8'd128));
        plan.push_back(plan_row(OP_ADD,   8'd1,   1'b1, 8'd0,   1'b0, 16'd1, ST_OK,    8'd128));
        plan.push_back(plan_row(OP_REL,   8'd1,   1'b1, 8'd0,   1'b1, 16'd0, ST_OK,    8'd128));
        plan.push_back(plan_row(OP_ALLOC, 8'd255, 1'b1, 8'd128, 1'b0, 16'd0, ST_OK,    8'd127));
        plan.push_back(plan_row(OP_ALLOC, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0, ST_OK,    8'd0));
        plan.push_back(plan_row(OP_ADD,   8'd127, 1'b0, 8'd0,   1'b0, 16'd0, ST_OK,    8'd0));
        plan.push_back(plan_row(OP_ADD,   8'd64,  1'b0, 8'd0,   1'b0, 16'd0, ST_OK,    8'd0));
        plan.push_back(plan_row(OP_NONE,  8'd0,   1'b0, 8'd0,   1'b0, 16'd0, ST_OK,    8'd0));
        plan.push_back(plan_row(OP_REL,   8'd64,  1'b0, 8'd0,   1'b0, 16'd0, ST_OK,    8'd0));
        plan.push_back(plan_row(OP_ALLOC, 8'd0,   1'b0, 8'd0,   1'b0, 16'd0, ST_OK,    8'd0));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_request(plan[i].r, plan[i].lit, plan[i].want);
        drain();

        // exhaust the table, then one more allocate
        idling_on = 1'b0;
        stim.handle    = 8'd0;
        stim.operation = OP_ALLOC;
        while (free_top != 0)
            send_request(stim, 1'b0, '0);
        send_request(stim, 1'b1, '{8'd0, 1'b0, 16'd0, ST_FULL, 8'd0});
        drain();

        for (n = 0; n < RANDOM_REQS; n++)
        begin
            idling_on = (n < 600) || (n >= 900 && n < 1500);
            if (n == 900)
                drain();
            sel = $urandom_range(0, 99);
            stim.handle    = 8'($urandom_range(0, 255));
            stim.operation = OP_ALLOC;
            if (sel >= 25 && sel < 55)
            begin
                stim.operation = OP_ADD;
                k = pick_entry(1'b0);
                if (k >= 0)
                    stim.handle = 8'(k + 1);
            end
            else if (sel >= 55 && sel < 88)
            begin
                stim.operation = OP_REL;
                k = pick_entry(1'b1);
                if (k >= 0)
                    stim.handle = 8'(k + 1);
            end
            else if (sel >= 88)
                stim.operation = 2'($urandom_range(0, 3));
            send_request(stim, 1'b0, '0);
        end
        drain();
        repeat (10) @(posedge clk);

        $display("%0d requests issued, %0d responses checked", reqs_sent, rsps_checked);
        $display("covered reset state, bad handles, underflow, full table, full-stack release");
        if (mismatch_count == 0)
            $display("refcounted_handle_allocator_core regression: pass");
        else
            $display("refcounted_handle_allocator_core regression: fail");
        $finish;
    end

endmodule
